@@ rtl/spt_pkg.sv @@
// Types and constants shared by the sorted point table cells and top level.
package spt_pkg;

  localparam int unsigned NAME_W  = 8;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned SQ_W    = 31;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned HITS_W  = 2;
  localparam logic [HITS_W-1:0] TRIPLE_HITS = 2'd3;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef struct packed {
    logic                      opcode;
    logic [NAME_W-1:0]         point_name;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
  } in_t;

  typedef struct packed {
    logic [NAME_W-1:0]         out_name;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic [KEY_W-1:0]          dist_squared;
    logic                      found_triple;
    logic                      table_full;
    logic                      last_of_run;
  } out_t;

  typedef struct packed {
    logic [NAME_W-1:0]         name;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [KEY_W-1:0]          key;
  } entry_t;

  typedef struct packed {
    entry_t            e;
    logic [HITS_W-1:0] hits;
  } cell_t;

  typedef enum logic [2:0] {
    CELL_HOLD   = 3'd0,
    CELL_INSERT = 3'd1,
    CELL_ROTATE = 3'd2,
    CELL_COUNT  = 3'd3,
    CELL_CLEAR  = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    entry_t                    new_entry;
    logic signed [COORD_W-1:0] probe_z;
  } cell_ctrl_t;

endpackage

@@ rtl/spt_cell.sv @@
// One table slot: holds an entry, takes part in parallel insert, rotation and z matching.
module spt_cell (
  input  logic               clk,
  input  spt_pkg::cell_ctrl_t ctrl_i,
  input  logic               occupied_i,
  input  logic               gt_left_i,
  input  spt_pkg::cell_t     left_i,
  input  spt_pkg::cell_t     rot_i,
  output logic               gt_o,
  output spt_pkg::cell_t     cell_o,
  output spt_pkg::cell_t     store_o
);
  import spt_pkg::*;

  cell_t cell_r;
  cell_t cell_nxt;
  logic  match;

  assign gt_o    = !occupied_i || (cell_r.e.key > ctrl_i.new_entry.key);
  assign match   = occupied_i && (cell_r.e.z == ctrl_i.probe_z) && (cell_r.hits != TRIPLE_HITS);
  assign store_o = cell_r;

  always_comb begin
    cell_o = cell_r;
    if (ctrl_i.op == CELL_COUNT && match) begin
      cell_o.hits = cell_r.hits + HITS_W'(1);
    end
  end

  always_comb begin
    cell_nxt = cell_r;
    case (ctrl_i.op)
      CELL_INSERT: begin
        if (gt_o) begin
          if (gt_left_i) begin
            cell_nxt = left_i;
          end else begin
            cell_nxt.e    = ctrl_i.new_entry;
            cell_nxt.hits = '0;
          end
        end
      end
      CELL_ROTATE, CELL_COUNT: begin
        cell_nxt = rot_i;
      end
      CELL_CLEAR: begin
        cell_nxt.hits = '0;
      end
      default: begin
        cell_nxt = cell_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
  end

endmodule

@@ rtl/sorted_point_table_by_distance.sv @@
// Sorted point table top level: request control, key computation and the chain of cells.
// Insert: the squares are registered, the key is summed and the entry is inserted in order;
//   then all count entries (size after the insert) go out in key order, one rotation per entry.
// Query: one broadcast and rotation per stored entry, then one response. Full insert: one response.
// Reset (rst_n low, synchronous) empties the table and the output register.
// Entry storage is not reset; only entries below the fill count are ever read.
module sorted_point_table_by_distance #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  spt_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output spt_pkg::out_t out_data
);
  import spt_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SUM  = 6'b000010,
    S_INS  = 6'b000100,
    S_EMIT = 6'b001000,
    S_QRY  = 6'b010000,
    S_RESP = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     steps_r, steps_nxt;
  logic              full_r, full_nxt;
  logic              query_r, query_nxt;
  logic [SQ_W-1:0]   sqx_r, sqy_r, sqz_r;
  entry_t            new_r, new_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_data_r, out_data_nxt;

  logic              in_accept;
  logic              out_free;
  logic signed [2*COORD_W-1:0] px, py, pz;
  cell_ctrl_t        ctrl;
  logic              any_triple;

  logic [CAPACITY-1:0] gt;
  logic [CAPACITY-1:0] occ;
  logic [CAPACITY-1:0] tri_hit;
  cell_t             cell_o [CAPACITY];
  cell_t             store  [CAPACITY];

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign px = in_data.coord_x * in_data.coord_x;
  assign py = in_data.coord_y * in_data.coord_y;
  assign pz = in_data.coord_z * in_data.coord_z;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      sqx_r <= px[SQ_W-1:0];
      sqy_r <= py[SQ_W-1:0];
      sqz_r <= pz[SQ_W-1:0];
    end
  end

  always_comb begin
    ctrl.op        = CELL_HOLD;
    ctrl.new_entry = new_r;
    ctrl.probe_z   = store[0].e.z;
    if (in_accept && in_data.opcode == OP_QUERY) begin
      ctrl.op = CELL_CLEAR;
    end else if (state_r == S_INS) begin
      ctrl.op = CELL_INSERT;
    end else if (state_r == S_EMIT && out_free) begin
      ctrl.op = CELL_ROTATE;
    end else if (state_r == S_QRY && steps_r != '0) begin
      ctrl.op = CELL_COUNT;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic  gt_left;
    cell_t left;
    cell_t rot;

    assign occ[i]     = (CW'(i) < count_r);
    assign tri_hit[i] = occ[i] && (store[i].hits == TRIPLE_HITS);

    if (i == 0) begin : g_head
      assign gt_left = 1'b0;
      assign left    = store[0];
    end else begin : g_body
      assign gt_left = gt[i-1];
      assign left    = store[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign rot = cell_o[0];
    end else begin : g_mid
      assign rot = (CW'(i + 1) == count_r) ? cell_o[0] : cell_o[i+1];
    end

    spt_cell u_cell (
      .clk        (clk),
      .ctrl_i     (ctrl),
      .occupied_i (occ[i]),
      .gt_left_i  (gt_left),
      .left_i     (left),
      .rot_i      (rot),
      .gt_o       (gt[i]),
      .cell_o     (cell_o[i]),
      .store_o    (store[i])
    );
  end

  assign any_triple = |tri_hit;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    steps_nxt     = steps_r;
    full_nxt      = full_r;
    query_nxt     = query_r;
    new_nxt       = new_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          new_nxt.name = in_data.point_name;
          new_nxt.x    = in_data.coord_x;
          new_nxt.y    = in_data.coord_y;
          new_nxt.z    = in_data.coord_z;
          if (in_data.opcode == OP_QUERY) begin
            query_nxt = 1'b1;
            full_nxt  = 1'b0;
            steps_nxt = count_r;
            state_nxt = S_QRY;
          end else if (count_r == CW'(CAPACITY)) begin
            query_nxt = 1'b0;
            full_nxt  = 1'b1;
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_SUM;
          end
        end
      end
      S_SUM: begin
        new_nxt.key = KEY_W'(sqx_r) + KEY_W'(sqy_r) + KEY_W'(sqz_r);
        state_nxt   = S_INS;
      end
      S_INS: begin
        count_nxt = count_r + CW'(1);
        steps_nxt = count_r + CW'(1);
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.out_name     = store[0].e.name;
          out_data_nxt.out_x        = store[0].e.x;
          out_data_nxt.out_y        = store[0].e.y;
          out_data_nxt.out_z        = store[0].e.z;
          out_data_nxt.dist_squared = store[0].e.key;
          out_data_nxt.found_triple = 1'b0;
          out_data_nxt.table_full   = 1'b0;
          out_data_nxt.last_of_run  = (steps_r == CW'(1));
          steps_nxt                 = steps_r - CW'(1);
          if (steps_r == CW'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_QRY: begin
        if (steps_r == '0) begin
          state_nxt = S_RESP;
        end else begin
          steps_nxt = steps_r - CW'(1);
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt              = '0;
          out_data_nxt.found_triple = query_r && any_triple;
          out_data_nxt.table_full   = full_r;
          out_data_nxt.last_of_run  = 1'b1;
          state_nxt                 = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      steps_r     <= '0;
      full_r      <= 1'b0;
      query_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      steps_r     <= steps_nxt;
      full_r      <= full_nxt;
      query_r     <= query_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    new_r      <= new_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
